// ===== rtl/mdio_mfm_pkg.sv =====
// types and constants shared by the clause 22 management frame master
// no dependencies; used by mdio_mfm_core and mdio_management_frame_master_unit
package mdio_mfm_pkg;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_READ  = 2'd1,
		ACT_WRITE = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	localparam int unsigned PRE_W    = 6;
	localparam int unsigned BITPOS_W = 7;
	localparam int unsigned IDX_W    = 5;
	localparam int unsigned DATA_W   = 16;

	localparam logic [PRE_W-1:0]    PRE_RESET  = 6'd32;
	localparam logic [BITPOS_W-1:0] FRAME_TAIL = 7'd32;
	localparam logic [3:0]          CMD_READ   = 4'b0110;
	localparam logic [3:0]          CMD_WRITE  = 4'b0101;
	localparam logic [1:0]          WRITE_TA   = 2'b10;

	localparam logic [IDX_W-1:0] IDX_TA         = 5'd14;
	localparam logic [IDX_W-1:0] IDX_DATA_FIRST = 5'd15;
	localparam logic [IDX_W-1:0] IDX_DATA_LAST  = 5'd30;
	localparam logic [IDX_W-1:0] IDX_LAST       = 5'd31;

	typedef struct packed {
		action_t             action;
		logic [4:0]          phy_address;
		logic [4:0]          register_address;
		logic [DATA_W-1:0]   write_data;
		logic                line_in;
	} item_t;

	typedef struct packed {
		logic                start_rejected;
		logic [DATA_W-1:0]   read_data;
		logic                done_res;
		logic                busy_res;
		logic                line_drive;
		logic                line_out;
	} result_t;

	typedef struct packed {
		logic                active;
		logic [BITPOS_W-1:0] bit_position;
	} status_t;

endpackage

// ===== rtl/mdio_management_frame_master_unit.sv =====
// clause 22 management frame master: stream ports, result register, config port
// depends on mdio_mfm_pkg and mdio_mfm_core
//
// channel  | direction | signals                       | content
// s_*      | in        | s_tvalid s_tready s_tuser s_tdata | one item per transaction
// m_*      | out       | m_tvalid m_tready m_tdata      | one result per input item
// cfg_*    | in        | cfg_valid cfg_ready cfg_data   | preamble_length write
//
// each input item yields its result in the next cycle, one per cycle if m_tready is high
// the single result register sets the rate; a new item is taken while it drains
// m_tready low holds the result and stalls s_tready; cfg_ready is always high
// arst_n clears the frame state and sets preamble_length to 32
module mdio_management_frame_master_unit #(
	parameter int PREAMBLE_MAX = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,   // action
	input  logic [31:0] s_tdata,   // phy_address, register_address, write_data, line_in, pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // line_out, line_drive, busy_res, done_res, read_data,
	                               // start_rejected, pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  cfg_data
);

	mdio_mfm_pkg::item_t   item;
	mdio_mfm_pkg::result_t res;
	mdio_mfm_pkg::result_t res_q;
	mdio_mfm_pkg::status_t stat;
	logic                  valid_q;
	logic                  s_fire;

	assign item.action           = mdio_mfm_pkg::action_t'(s_tuser);
	assign item.phy_address      = s_tdata[4:0];
	assign item.register_address = s_tdata[9:5];
	assign item.write_data       = s_tdata[25:10];
	assign item.line_in          = s_tdata[26];

	assign s_tready  = !valid_q || m_tready;
	assign s_fire    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	mdio_mfm_core #(
		.PREAMBLE_MAX(PREAMBLE_MAX)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (s_fire),
		.item    (item),
		.cfg_we  (cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.res     (res),
		.stat    (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tready) begin
			valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {3'd0, res_q};

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!res_q.done_res || res_q.busy_res))
		else $error("done without busy");

	a_released_low: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res_q.line_drive |-> !res_q.line_out)
		else $error("line_out high while released");

	a_bitpos_range: assert property (@(posedge clk) disable iff (!arst_n)
		stat.active |-> (stat.bit_position != '0
			&& stat.bit_position <= 7'(PREAMBLE_MAX) + mdio_mfm_pkg::FRAME_TAIL))
		else $error("bit position out of range in active frame");

	a_start_takes: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && !stat.active && (s_tuser == mdio_mfm_pkg::ACT_READ
			|| s_tuser == mdio_mfm_pkg::ACT_WRITE) |=> stat.active)
		else $error("accepted start did not open a frame");

	a_done_closes: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && res.done_res |=> !stat.active)
		else $error("frame still active after done");

endmodule

// ===== rtl/mdio_mfm_core.sv =====
// frame sequencer: preamble register, frame state and one bit period per tick
// depends on mdio_mfm_pkg
module mdio_mfm_core #(
	parameter int PREAMBLE_MAX = 32
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    step,
	input  mdio_mfm_pkg::item_t                     item,
	input  logic                                    cfg_we,
	input  logic [mdio_mfm_pkg::PRE_W-1:0]          cfg_data,
	output mdio_mfm_pkg::result_t                   res,
	output mdio_mfm_pkg::status_t                   stat
);

	localparam logic [mdio_mfm_pkg::PRE_W-1:0] PRE_MAX = mdio_mfm_pkg::PRE_W'(PREAMBLE_MAX);

	logic [mdio_mfm_pkg::PRE_W-1:0]    preamble_q;
	logic                              active_q, active_d;
	logic                              is_write_q, is_write_d;
	logic [mdio_mfm_pkg::BITPOS_W-1:0] bitpos_q, bitpos_d;
	logic [31:0]                       out_shift_q, out_shift_d;
	logic [mdio_mfm_pkg::DATA_W-1:0]   in_shift_q, in_shift_d;
	logic [mdio_mfm_pkg::PRE_W-1:0]    pre_sat;
	logic [mdio_mfm_pkg::IDX_W-1:0]    idx;
	logic [13:0]                       header;

	assign pre_sat = (preamble_q > PRE_MAX) ? PRE_MAX : preamble_q;
	assign idx     = mdio_mfm_pkg::IDX_W'(mdio_mfm_pkg::FRAME_TAIL - bitpos_q);
	assign header  = {(item.action == mdio_mfm_pkg::ACT_WRITE) ? mdio_mfm_pkg::CMD_WRITE
			: mdio_mfm_pkg::CMD_READ, item.phy_address, item.register_address};

	always_comb begin
		res         = '0;
		res.busy_res = active_q;
		active_d    = active_q;
		is_write_d  = is_write_q;
		bitpos_d    = bitpos_q;
		out_shift_d = out_shift_q;
		in_shift_d  = in_shift_q;
		unique case (item.action)
			mdio_mfm_pkg::ACT_READ, mdio_mfm_pkg::ACT_WRITE: begin
				if (active_q) begin
					res.start_rejected = 1'b1;
				end else begin
					is_write_d  = (item.action == mdio_mfm_pkg::ACT_WRITE);
					out_shift_d = {header, 18'd0};
					if (is_write_d) begin
						out_shift_d[17:0] = {mdio_mfm_pkg::WRITE_TA, item.write_data};
					end
					in_shift_d   = '0;
					bitpos_d     = mdio_mfm_pkg::BITPOS_W'(pre_sat) + mdio_mfm_pkg::FRAME_TAIL;
					active_d     = 1'b1;
					res.busy_res = 1'b1;
				end
			end
			mdio_mfm_pkg::ACT_TICK: begin
				if (active_q) begin
					if (bitpos_q > mdio_mfm_pkg::FRAME_TAIL) begin
						res.line_out   = 1'b1;
						res.line_drive = 1'b1;
					end else begin
						if (is_write_q || idx < mdio_mfm_pkg::IDX_TA) begin
							res.line_out   = out_shift_q[31];
							res.line_drive = 1'b1;
							out_shift_d    = {out_shift_q[30:0], 1'b0};
						end else if (idx >= mdio_mfm_pkg::IDX_DATA_FIRST
								&& idx <= mdio_mfm_pkg::IDX_DATA_LAST) begin
							in_shift_d = {in_shift_q[mdio_mfm_pkg::DATA_W-2:0], item.line_in};
						end
						if (idx == mdio_mfm_pkg::IDX_LAST) begin
							res.done_res = 1'b1;
							if (!is_write_q) begin
								res.read_data = in_shift_q;
							end
						end
					end
					if (bitpos_q != '0) begin
						bitpos_d = bitpos_q - mdio_mfm_pkg::BITPOS_W'(1);
					end
					if (res.done_res || bitpos_d == '0) begin
						active_d = 1'b0;
					end
				end
			end
			mdio_mfm_pkg::ACT_NOP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preamble_q  <= mdio_mfm_pkg::PRE_RESET;
			active_q    <= 1'b0;
			is_write_q  <= 1'b0;
			bitpos_q    <= '0;
			out_shift_q <= '0;
			in_shift_q  <= '0;
		end else begin
			if (cfg_we) begin
				preamble_q <= cfg_data;
			end
			if (step) begin
				active_q    <= active_d;
				is_write_q  <= is_write_d;
				bitpos_q    <= bitpos_d;
				out_shift_q <= out_shift_d;
				in_shift_q  <= in_shift_d;
			end
		end
	end

	assign stat.active       = active_q;
	assign stat.bit_position = bitpos_q;

endmodule
